// ===== design/tsa_pkg.sv =====
// Shared types and constants for the TSP swap annealing engine.
// Depends on nothing; imported by the walker and the top level.
package tsa_pkg;

    localparam int LEN_W  = 36;
    localparam int TEMP_W = 40;
    localparam int CFG_W  = 40;
    localparam int PROD_W = 56;

    localparam logic [LEN_W-1:0]  LEN_MAX         = {LEN_W{1'b1}};
    localparam logic [10:0]       PC_RESET        = 11'd2;
    localparam logic [TEMP_W-1:0] INIT_TEMP_RESET = 40'd65536000;
    localparam logic [15:0]       COOL_RESET      = 16'd52429;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [1:0] REG_INIT_TEMP   = 2'd1;
    localparam logic [1:0] REG_COOLING     = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } walk_stat_t;

endpackage

// ===== design/tsa_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on nothing.
module tsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/tsa_sqrt_pipe.sv =====
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Depends on nothing.
module tsa_sqrt_pipe #(
    parameter int IN_W = 52
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  logic [IN_W-1:0]     in_rad,
    output logic                out_vld,
    output logic [IN_W/2-1:0]   out_root
);

    localparam int RW = IN_W / 2;

    logic [IN_W-1:0] rad_q  [RW];
    logic [RW+1:0]   rem_q  [RW];
    logic [RW-1:0]   root_q [RW];
    logic            vld_q  [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic [IN_W-1:0] rad_i;
        logic [RW+1:0]   rem_i;
        logic [RW-1:0]   root_i;
        logic            vld_i;
        logic [RW+1:0]   cand;
        logic [RW+1:0]   test;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign rad_i  = in_rad;
            assign rem_i  = '0;
            assign root_i = '0;
            assign vld_i  = in_vld;
        end
        else
        begin : g_next
            assign rad_i  = rad_q[k-1];
            assign rem_i  = rem_q[k-1];
            assign root_i = root_q[k-1];
            assign vld_i  = vld_q[k-1];
        end

        assign cand = {rem_i[RW-1:0], rad_i[IN_W-1 -: 2]};
        assign test = {root_i, 2'b01};
        assign ge   = (cand >= test);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_q[k] <= 1'b0;
            end
            else
            begin
                vld_q[k] <= vld_i;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_q[k]  <= rad_i << 2;
            rem_q[k]  <= ge ? (cand - test) : cand;
            root_q[k] <= {root_i[RW-2:0], ge};
        end
    end

    assign out_vld  = vld_q[RW-1];
    assign out_root = root_q[RW-1];

endmodule

// ===== design/tsa_walker.sv =====
// Tour length walker: holds the coordinate RAMs, streams the tour, sums edges.
// Depends on tsa_pkg, tsa_ram and tsa_sqrt_pipe.
module tsa_walker
    import tsa_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [$clog2(MAX_POINTS+1)-1:0]   count,
    output logic [$clog2(MAX_POINTS)-1:0]     tour_raddr,
    input  logic [$clog2(MAX_POINTS)-1:0]     tour_rdata,
    input  logic                              xy_we,
    input  logic [$clog2(MAX_POINTS)-1:0]     xy_waddr,
    input  logic signed [COORD_BITS-1:0]      x_wdata,
    input  logic signed [COORD_BITS-1:0]      y_wdata,
    output logic [LEN_W-1:0]                  sum,
    output walk_stat_t                        stat
);

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int C    = COORD_BITS;
    localparam int SQW  = 2 * C + 3;
    localparam int RADW = 2 * C + 20;
    localparam int RW   = RADW / 2;

    logic signed [C-1:0] x_rdata, y_rdata;

    tsa_ram #(.WIDTH(C), .DEPTH(MAX_POINTS)) u_x_ram (
        .clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(x_wdata),
        .re(1'b1), .raddr(tour_rdata), .rdata(x_rdata)
    );

    tsa_ram #(.WIDTH(C), .DEPTH(MAX_POINTS)) u_y_ram (
        .clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(y_wdata),
        .re(1'b1), .raddr(tour_rdata), .rdata(y_rdata)
    );

    logic          busy_reg;
    logic [CW-1:0] cnt_reg, rd_cnt_reg, edge_cnt_reg;
    logic          t1_vld_reg, t1_first_reg, t1_last_reg;
    logic          c_vld_reg, c_first_reg, c_last_reg;
    logic          close_reg, pair_vld_reg, d_vld_reg, q_vld_reg, s_vld_reg;
    logic          done_reg;
    logic [LEN_W-1:0] sum_reg;

    logic signed [C-1:0] prev_x_reg, prev_y_reg, first_x_reg, first_y_reg;
    logic signed [C-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [C:0]          dx_reg, dy_reg;
    logic [2*C+1:0]      sqx_reg, sqy_reg;
    logic [SQW-1:0]      s_reg;

    logic          issue;
    logic signed [C:0] dx_s, dy_s;
    logic          root_vld;
    logic [RW-1:0] root;
    logic [LEN_W:0] sum_ext;

    assign issue      = busy_reg && (rd_cnt_reg < cnt_reg);
    assign tour_raddr = rd_cnt_reg[AW-1:0];
    assign dx_s       = {ax_reg[C-1], ax_reg} - {bx_reg[C-1], bx_reg};
    assign dy_s       = {ay_reg[C-1], ay_reg} - {by_reg[C-1], by_reg};
    assign sum_ext    = {1'b0, sum_reg} + (LEN_W+1)'(root);

    tsa_sqrt_pipe #(.IN_W(RADW)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .in_vld(s_vld_reg),
        .in_rad(RADW'({s_reg, 16'h0000})),
        .out_vld(root_vld), .out_root(root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            rd_cnt_reg   <= '0;
            edge_cnt_reg <= '0;
            t1_vld_reg   <= 1'b0;
            c_vld_reg    <= 1'b0;
            close_reg    <= 1'b0;
            pair_vld_reg <= 1'b0;
            d_vld_reg    <= 1'b0;
            q_vld_reg    <= 1'b0;
            s_vld_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg     <= 1'b1;
                rd_cnt_reg   <= '0;
                edge_cnt_reg <= '0;
            end
            else
            begin
                if (issue)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                if (root_vld)
                begin
                    edge_cnt_reg <= edge_cnt_reg + 1'b1;
                end
                if (busy_reg && edge_cnt_reg == cnt_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            t1_vld_reg   <= issue;
            c_vld_reg    <= t1_vld_reg;
            pair_vld_reg <= (c_vld_reg && !c_first_reg) || close_reg;
            if (c_vld_reg && c_last_reg)
            begin
                close_reg <= 1'b1;
            end
            else
            begin
                close_reg <= 1'b0;
            end
            d_vld_reg <= pair_vld_reg;
            q_vld_reg <= d_vld_reg;
            s_vld_reg <= q_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cnt_reg <= count;
            sum_reg <= '0;
        end
        else if (root_vld)
        begin
            sum_reg <= sum_ext[LEN_W] ? LEN_MAX : sum_ext[LEN_W-1:0];
        end
        t1_first_reg <= (rd_cnt_reg == '0);
        t1_last_reg  <= (rd_cnt_reg == cnt_reg - 1'b1);
        c_first_reg  <= t1_first_reg;
        c_last_reg   <= t1_last_reg;
        if (c_vld_reg)
        begin
            prev_x_reg <= x_rdata;
            prev_y_reg <= y_rdata;
            ax_reg     <= prev_x_reg;
            ay_reg     <= prev_y_reg;
            bx_reg     <= x_rdata;
            by_reg     <= y_rdata;
            if (c_first_reg)
            begin
                first_x_reg <= x_rdata;
                first_y_reg <= y_rdata;
            end
        end
        else if (close_reg)
        begin
            // close the loop: last point back to the first
            ax_reg <= prev_x_reg;
            ay_reg <= prev_y_reg;
            bx_reg <= first_x_reg;
            by_reg <= first_y_reg;
        end
        dx_reg  <= dx_s[C] ? (C+1)'(-dx_s) : (C+1)'(dx_s);
        dy_reg  <= dy_s[C] ? (C+1)'(-dy_s) : (C+1)'(dy_s);
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
        s_reg   <= SQW'(sqx_reg) + SQW'(sqy_reg);
    end

    assign sum       = sum_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== design/tsp_swap_annealing_engine.sv =====
// Top level of the TSP swap annealing engine: command sequencer, tour and best RAMs.
// Depends on tsa_pkg, tsa_ram and tsa_walker.
//
// Usage. Input beats carry a command: load a point into a tour slot, run one
// anneal step (swap two slots, recompute the closed tour, keep or undo), or
// read a slot of the best tour. Every input beat yields exactly one output beat
// carrying accepted, improved, both tour lengths, the read point and error.
// Configuration (point count, initial temperature, cooling factor) is written
// through cfg_we/cfg_index/cfg_data while the engine is idle.
//
// Timing. A load or a rejected item goes straight to the output state; a read
// first passes an issue state and a data state. A step walks the N tour slots
// (one tour slot per cycle, then the square-root pipeline drains), plus a full
// copy of all MAX_POINTS slots into the best RAM when it improves. The first
// step or read after a load also refreshes: one walk and one copy before its
// own work. The single read port of the tour RAM sets the walk rate.
//
// Reset clears totals, sets the temperature to its reset value and marks the
// tour stale; the RAMs keep no reset. A stalled receiver holds the output
// beat; the next input beat is still taken and waits only at its end.
module tsp_swap_annealing_engine
    import tsa_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           command,
    input  logic [9:0]           position,
    input  logic [9:0]           other_position,
    input  logic signed [15:0]   point_x,
    input  logic signed [15:0]   point_y,
    input  logic [15:0]          exp_variate,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 accepted,
    output logic                 improved,
    output logic [LEN_W-1:0]     current_length,
    output logic [LEN_W-1:0]     best_length,
    output logic [9:0]           tour_point,
    output logic                 error
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_REF_WALK = 16'h0002,
        ST_REF_COPY = 16'h0004,
        ST_SW_RA    = 16'h0008,
        ST_SW_RB    = 16'h0010,
        ST_SW_WA    = 16'h0020,
        ST_SW_WB    = 16'h0040,
        ST_WALK     = 16'h0080,
        ST_DECIDE   = 16'h0100,
        ST_REST_A   = 16'h0200,
        ST_REST_B   = 16'h0400,
        ST_COPY     = 16'h0800,
        ST_COOL     = 16'h1000,
        ST_RD_ISSUE = 16'h2000,
        ST_RD_DATA  = 16'h4000,
        ST_DONE     = 16'h8000
    } state_t;

    // control state
    state_t              state_reg, state_next;
    logic                stale_reg, stale_next;
    logic                out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]    cur_reg, cur_next, best_reg, best_next;
    logic [TEMP_W-1:0]   temp_reg, temp_next;
    logic [10:0]         pc_reg;
    logic [TEMP_W-1:0]   init_temp_reg;
    logic [15:0]         cool_reg;
    logic [CW-1:0]       cp_cnt_reg;
    logic                cp_wv_reg;

    // payload
    logic [1:0]          cmd_reg, cmd_next;
    logic [9:0]          pos_reg, pos_next, oth_reg, oth_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [AW-1:0]       ta_reg, ta_next, tb_reg, tb_next;
    logic                racc_reg, racc_next, rimp_reg, rimp_next, rerr_reg, rerr_next;
    logic [9:0]          rtp_reg, rtp_next;
    logic [AW-1:0]       cp_wa_reg;
    logic                o_acc_reg, o_imp_reg, o_err_reg;
    logic [LEN_W-1:0]    o_cur_reg, o_best_reg;
    logic [9:0]          o_tp_reg;
    logic                load_out;

    // RAM ports and walker hookup
    logic                tour_we;
    logic [AW-1:0]       tour_waddr, tour_wdata, tour_raddr, tour_rdata;
    logic [AW-1:0]       walk_raddr, best_rdata;
    logic                xy_we;
    logic                walk_start, copy_start, copy_active, copy_done, cp_issue;
    logic [LEN_W-1:0]    walk_sum;
    walk_stat_t          walk_stat;

    logic signed [31:0]         x_wide, y_wide;
    logic                       count_ok, load_ok, step_ok, read_ok;
    logic [PROD_W-1:0]          cool_prod;
    logic [LEN_W-1:0]           delta;

    assign x_wide    = 32'(point_x);
    assign y_wide    = 32'(point_y);
    assign count_ok  = (pc_reg >= 11'd2) && (32'(pc_reg) <= MAX_POINTS);
    assign load_ok   = (32'(position) < MAX_POINTS);
    assign read_ok   = count_ok && ({1'b0, position} < pc_reg);
    assign step_ok   = read_ok && ({1'b0, other_position} < pc_reg)
                       && (position != other_position);
    assign cool_prod = temp_reg * cool_reg;
    assign delta     = walk_sum - cur_reg;

    assign copy_active = (state_reg == ST_REF_COPY) || (state_reg == ST_COPY);
    assign cp_issue    = copy_active && (cp_cnt_reg < MAXC);
    assign copy_done   = copy_active && (cp_cnt_reg == MAXC) && !cp_wv_reg;

    assign in_ready = (state_reg == ST_IDLE);

    // tour RAM read address: copy sweep, swap reads, else the walker
    always_comb
    begin
        if (copy_active)
        begin
            tour_raddr = cp_cnt_reg[AW-1:0];
        end
        else if (state_reg == ST_SW_RA)
        begin
            tour_raddr = AW'(pos_reg);
        end
        else if (state_reg == ST_SW_RB)
        begin
            tour_raddr = AW'(oth_reg);
        end
        else
        begin
            tour_raddr = walk_raddr;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        stale_next     = stale_reg;
        out_valid_next = out_valid_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        temp_next      = temp_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        oth_next       = oth_reg;
        prod_next      = prod_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        racc_next      = racc_reg;
        rimp_next      = rimp_reg;
        rerr_next      = rerr_reg;
        rtp_next       = rtp_reg;
        tour_we        = 1'b0;
        tour_waddr     = AW'(pos_reg);
        tour_wdata     = ta_reg;
        xy_we          = 1'b0;
        walk_start     = 1'b0;
        copy_start     = 1'b0;
        load_out       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    pos_next   = position;
                    oth_next   = other_position;
                    prod_next  = temp_reg * exp_variate;
                    racc_next  = 1'b0;
                    rimp_next  = 1'b0;
                    rerr_next  = 1'b0;
                    rtp_next   = '0;
                    state_next = ST_DONE;
                    case (command)
                        CMD_LOAD:
                        begin
                            if (!load_ok)
                            begin
                                rerr_next = 1'b1;
                            end
                            else
                            begin
                                tour_we    = 1'b1;
                                tour_waddr = AW'(position);
                                tour_wdata = AW'(position);
                                xy_we      = 1'b1;
                                temp_next  = init_temp_reg;
                                stale_next = 1'b1;
                            end
                        end
                        CMD_STEP:
                        begin
                            if (!step_ok)
                            begin
                                rerr_next = 1'b1;
                            end
                            else if (stale_reg)
                            begin
                                walk_start = 1'b1;
                                state_next = ST_REF_WALK;
                            end
                            else
                            begin
                                state_next = ST_SW_RA;
                            end
                        end
                        CMD_READ:
                        begin
                            if (!read_ok)
                            begin
                                rerr_next = 1'b1;
                            end
                            else if (stale_reg)
                            begin
                                walk_start = 1'b1;
                                state_next = ST_REF_WALK;
                            end
                            else
                            begin
                                state_next = ST_RD_ISSUE;
                            end
                        end
                        default:
                        begin
                            rerr_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_REF_WALK:
            begin
                if (walk_stat.done)
                begin
                    cur_next   = walk_sum;
                    best_next  = walk_sum;
                    copy_start = 1'b1;
                    state_next = ST_REF_COPY;
                end
            end
            ST_REF_COPY:
            begin
                if (copy_done)
                begin
                    stale_next = 1'b0;
                    state_next = (cmd_reg == CMD_STEP) ? ST_SW_RA : ST_RD_ISSUE;
                end
            end
            ST_SW_RA:
            begin
                state_next = ST_SW_RB;
            end
            ST_SW_RB:
            begin
                ta_next    = tour_rdata;
                state_next = ST_SW_WA;
            end
            ST_SW_WA:
            begin
                tb_next    = tour_rdata;
                tour_we    = 1'b1;
                tour_waddr = AW'(pos_reg);
                tour_wdata = tour_rdata;
                state_next = ST_SW_WB;
            end
            ST_SW_WB:
            begin
                tour_we    = 1'b1;
                tour_waddr = AW'(oth_reg);
                tour_wdata = ta_reg;
                walk_start = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (walk_stat.done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if ((walk_sum < cur_reg) || ({delta, 20'h00000} < prod_reg))
                begin
                    racc_next = 1'b1;
                    cur_next  = walk_sum;
                    if (walk_sum < best_reg)
                    begin
                        best_next  = walk_sum;
                        rimp_next  = 1'b1;
                        copy_start = 1'b1;
                        state_next = ST_COPY;
                    end
                    else
                    begin
                        state_next = ST_COOL;
                    end
                end
                else
                begin
                    state_next = ST_REST_A;
                end
            end
            ST_REST_A:
            begin
                tour_we    = 1'b1;
                tour_waddr = AW'(pos_reg);
                tour_wdata = ta_reg;
                state_next = ST_REST_B;
            end
            ST_REST_B:
            begin
                tour_we    = 1'b1;
                tour_waddr = AW'(oth_reg);
                tour_wdata = tb_reg;
                state_next = ST_COOL;
            end
            ST_COPY:
            begin
                if (copy_done)
                begin
                    state_next = ST_COOL;
                end
            end
            ST_COOL:
            begin
                temp_next  = cool_prod[PROD_W-1:16];
                state_next = ST_DONE;
            end
            ST_RD_ISSUE:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                rtp_next   = 10'(best_rdata);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold here while the previous beat is still waiting
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stale_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            best_reg      <= '0;
            temp_reg      <= INIT_TEMP_RESET;
            pc_reg        <= PC_RESET;
            init_temp_reg <= INIT_TEMP_RESET;
            cool_reg      <= COOL_RESET;
            cp_cnt_reg    <= '0;
            cp_wv_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stale_reg     <= stale_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            best_reg      <= best_next;
            temp_reg      <= temp_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POINT_COUNT: pc_reg        <= cfg_data[10:0];
                    REG_INIT_TEMP:   init_temp_reg <= cfg_data[TEMP_W-1:0];
                    REG_COOLING:     cool_reg      <= cfg_data[15:0];
                    default:         ;
                endcase
            end
            // copy sweep: read tour slot k, write best slot k in the next cycle
            if (copy_start)
            begin
                cp_cnt_reg <= '0;
                cp_wv_reg  <= 1'b0;
            end
            else
            begin
                cp_wv_reg <= cp_issue;
                if (cp_issue)
                begin
                    cp_cnt_reg <= cp_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        pos_reg   <= pos_next;
        oth_reg   <= oth_next;
        prod_reg  <= prod_next;
        ta_reg    <= ta_next;
        tb_reg    <= tb_next;
        racc_reg  <= racc_next;
        rimp_reg  <= rimp_next;
        rerr_reg  <= rerr_next;
        rtp_reg   <= rtp_next;
        cp_wa_reg <= cp_cnt_reg[AW-1:0];
        if (load_out)
        begin
            o_acc_reg  <= racc_reg;
            o_imp_reg  <= rimp_reg;
            o_err_reg  <= rerr_reg;
            o_tp_reg   <= rtp_reg;
            o_cur_reg  <= cur_reg;
            o_best_reg <= best_reg;
        end
    end

    tsa_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_tour_ram (
        .clk(clk), .we(tour_we), .waddr(tour_waddr), .wdata(tour_wdata),
        .re(1'b1), .raddr(tour_raddr), .rdata(tour_rdata)
    );

    tsa_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_best_ram (
        .clk(clk), .we(cp_wv_reg), .waddr(cp_wa_reg), .wdata(tour_rdata),
        .re(state_reg == ST_RD_ISSUE), .raddr(AW'(pos_reg)), .rdata(best_rdata)
    );

    tsa_walker #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_walker (
        .clk(clk), .rst_n(rst_n), .start(walk_start), .count(CW'(pc_reg)),
        .tour_raddr(walk_raddr), .tour_rdata(tour_rdata),
        .xy_we(xy_we), .xy_waddr(AW'(position)),
        .x_wdata(x_wide[COORD_BITS-1:0]), .y_wdata(y_wide[COORD_BITS-1:0]),
        .sum(walk_sum), .stat(walk_stat)
    );

    assign out_valid      = out_valid_reg;
    assign accepted       = o_acc_reg;
    assign improved       = o_imp_reg;
    assign error          = o_err_reg;
    assign tour_point     = o_tp_reg;
    assign current_length = o_cur_reg;
    assign best_length    = o_best_reg;

endmodule

// ===== design/tsa_checker.sv =====
// Port-level checker for the TSP swap annealing engine, bound to the top level.
// Depends on the top level's port list only.
module tsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        accepted,
    input logic        improved,
    input logic [35:0] current_length,
    input logic [35:0] best_length,
    input logic [9:0]  tour_point,
    input logic        error
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(current_length)
        && $stable(best_length) && $stable(tour_point) && $stable(error))
        else $error("output beat changed while stalled");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> !accepted && !improved && tour_point == 10'd0)
        else $error("rejected item reports a result");

    a_imp_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && improved |-> accepted && current_length == best_length)
        else $error("improvement without matching accepted length");

    a_best_le: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> best_length <= current_length)
        else $error("best length above current length");

endmodule

bind tsp_swap_annealing_engine tsa_checker u_tsa_checker (.*);
